// ===== rtl/tgad_pkg.sv =====
// Shared types and constants of the TGA stream decoder.
package tgad_pkg;

  // Default depth of the token queue between parser and run builder
  localparam int unsigned TGAD_FIFO_DEPTH = 4;

  // Result kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // Header error codes, in priority order
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_ZERO_SIZE = 2'd1;
  localparam logic [1:0] ERR_BAD_DEPTH = 2'd2;
  localparam logic [1:0] ERR_BAD_TYPE  = 2'd3;

  // Largest run a packet can describe
  localparam logic [7:0] MAX_RUN = 8'd128;

  // Token commands passed from parser to run builder
  typedef enum logic [1:0] {
    TOK_START = 2'd0,
    TOK_PIXEL = 2'd1,
    TOK_ERROR = 2'd2
  } tok_cmd_t;

  typedef struct packed {
    tok_cmd_t    cmd;
    logic [31:0] word;
    logic        is_run;
    logic [7:0]  pkt_left;
    logic [15:0] width;
    logic [15:0] height;
    logic [1:0]  err;
  } tok_t;

endpackage

// ===== rtl/tgad_front.sv =====
// Byte parser: header, ID skip, packet headers and pixel assembly into tokens.
module tgad_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           byte_take,
  input  logic [7:0]     file_byte,
  input  logic           first_byte,
  output logic           tok_push,
  output tgad_pkg::tok_t tok
);
  import tgad_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_IDSKIP = 5'b00100,
    PH_PKTHDR = 5'b01000,
    PH_PIXEL  = 5'b10000
  } phase_t;

  localparam logic [4:0] HDR_ID_LEN   = 5'd0;
  localparam logic [4:0] HDR_TYPE     = 5'd2;
  localparam logic [4:0] HDR_WIDTH_L  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_H  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_L = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_H = 5'd15;
  localparam logic [4:0] HDR_DEPTH    = 5'd16;
  localparam logic [4:0] HDR_LAST     = 5'd17;

  localparam logic [7:0] TYPE_RAW = 8'd2;
  localparam logic [7:0] TYPE_RLE = 8'd10;

  localparam logic [4:0] DEPTH_GRAY = 5'd1;
  localparam logic [4:0] DEPTH_RGB  = 5'd3;
  localparam logic [4:0] DEPTH_RGBA = 5'd4;

  phase_t      phase_r, phase_nxt, phase_eff;
  logic [4:0]  hdr_idx_r, hdr_idx_nxt, hdr_idx_eff;
  logic [7:0]  id_skip_r, id_skip_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [4:0]  depth_r, depth_nxt;
  logic        rle_r, rle_nxt;
  logic        type_ok_r, type_ok_nxt;
  logic [7:0]  pkt_left_r, pkt_left_nxt;
  logic        pkt_run_r, pkt_run_nxt;
  logic [31:0] asm_r, asm_nxt, asm_ins;
  logic [1:0]  bip_r, bip_nxt;
  logic [1:0]  err;
  logic        depth_ok;
  phase_t      data_phase;

  always_comb begin
    // A first-byte mark restarts the parse at header byte zero
    phase_eff   = first_byte ? PH_HEADER : phase_r;
    hdr_idx_eff = first_byte ? HDR_ID_LEN : hdr_idx_r;
    data_phase  = rle_r ? PH_PKTHDR : PH_PIXEL;

    depth_ok = depth_r inside {DEPTH_GRAY, DEPTH_RGB, DEPTH_RGBA};
    if (width_r == 16'd0 || height_r == 16'd0) begin
      err = ERR_ZERO_SIZE;
    end else if (!depth_ok) begin
      err = ERR_BAD_DEPTH;
    end else if (!type_ok_r) begin
      err = ERR_BAD_TYPE;
    end else begin
      err = ERR_NONE;
    end

    // Insert the byte into its lane, or replicate a gray sample
    asm_ins = asm_r;
    asm_ins[{bip_r, 3'b000} +: 8] = file_byte;
    if (depth_r == DEPTH_GRAY) begin
      asm_ins = {4{file_byte}};
    end

    phase_nxt    = phase_r;
    hdr_idx_nxt  = hdr_idx_r;
    id_skip_nxt  = id_skip_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    depth_nxt    = depth_r;
    rle_nxt      = rle_r;
    type_ok_nxt  = type_ok_r;
    pkt_left_nxt = pkt_left_r;
    pkt_run_nxt  = pkt_run_r;
    asm_nxt      = asm_r;
    bip_nxt      = bip_r;

    tok_push     = 1'b0;
    tok.cmd      = TOK_PIXEL;
    tok.word     = asm_ins;
    tok.is_run   = rle_r && pkt_run_r;
    tok.pkt_left = pkt_left_r;
    tok.width    = width_r;
    tok.height   = height_r;
    tok.err      = err;

    if (byte_take && first_byte) begin
      type_ok_nxt = 1'b0;
      rle_nxt     = 1'b0;
    end

    if (byte_take) begin
      case (phase_eff)
        PH_HEADER: begin
          case (hdr_idx_eff)
            HDR_ID_LEN:   id_skip_nxt = file_byte;
            HDR_TYPE: begin
              rle_nxt     = (file_byte == TYPE_RLE);
              type_ok_nxt = (file_byte == TYPE_RAW) || (file_byte == TYPE_RLE);
            end
            HDR_WIDTH_L:  width_nxt[7:0]   = file_byte;
            HDR_WIDTH_H:  width_nxt[15:8]  = file_byte;
            HDR_HEIGHT_L: height_nxt[7:0]  = file_byte;
            HDR_HEIGHT_H: height_nxt[15:8] = file_byte;
            HDR_DEPTH:    depth_nxt        = file_byte[7:3];
            default: ;
          endcase
          if (hdr_idx_eff != HDR_LAST) begin
            hdr_idx_nxt = hdr_idx_eff + 5'd1;
            phase_nxt   = PH_HEADER;
          end else begin
            // Check the header, then hand the image size to the run builder
            tok_push = 1'b1;
            hdr_idx_nxt = hdr_idx_eff;
            if (err != ERR_NONE) begin
              tok.cmd   = TOK_ERROR;
              phase_nxt = PH_IDLE;
            end else begin
              tok.cmd      = TOK_START;
              asm_nxt      = '1;
              bip_nxt      = 2'd0;
              pkt_left_nxt = 8'd0;
              pkt_run_nxt  = 1'b0;
              phase_nxt    = (id_skip_r != 8'd0) ? PH_IDSKIP : data_phase;
            end
          end
        end
        PH_IDSKIP: begin
          id_skip_nxt = id_skip_r - 8'd1;
          if (id_skip_nxt == 8'd0) begin
            phase_nxt = data_phase;
          end
        end
        PH_PKTHDR: begin
          // Both packet kinds carry count minus one in the low seven bits
          pkt_run_nxt  = file_byte[7];
          pkt_left_nxt = {1'b0, file_byte[6:0]} + 8'd1;
          bip_nxt      = 2'd0;
          phase_nxt    = PH_PIXEL;
        end
        PH_PIXEL: begin
          asm_nxt = asm_ins;
          if (({3'b000, bip_r} + 5'd1) < depth_r) begin
            bip_nxt = bip_r + 2'd1;
          end else begin
            bip_nxt  = 2'd0;
            tok_push = 1'b1;
            if (rle_r) begin
              pkt_left_nxt = pkt_run_r ? 8'd0 : pkt_left_r - 8'd1;
              if (pkt_left_nxt == 8'd0) begin
                phase_nxt = PH_PKTHDR;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Advance parser control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      hdr_idx_r   <= 5'd0;
      id_skip_r   <= 8'd0;
      depth_r     <= 5'd0;
      rle_r       <= 1'b0;
      type_ok_r   <= 1'b0;
      pkt_left_r  <= 8'd0;
      pkt_run_r   <= 1'b0;
      bip_r       <= 2'd0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      id_skip_r   <= id_skip_nxt;
      depth_r     <= depth_nxt;
      rle_r       <= rle_nxt;
      type_ok_r   <= type_ok_nxt;
      pkt_left_r  <= pkt_left_nxt;
      pkt_run_r   <= pkt_run_nxt;
      bip_r       <= bip_nxt;
    end
  end

  // Hold header sizes and the pixel assembly
  always_ff @(posedge clk) begin
    width_r  <= width_nxt;
    height_r <= height_nxt;
    asm_r    <= asm_nxt;
  end

endmodule

// ===== rtl/tgad_fifo.sv =====
// Token queue between the byte parser and the run builder.
module tgad_fifo #(
  parameter int unsigned DEPTH = tgad_pkg::TGAD_FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tgad_pkg::tok_t push_tok,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tgad_pkg::tok_t head_tok
);
  import tgad_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  tok_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_tok   = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming token
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> !full)
    else $error("token queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("token queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("token queue count out of range");
`endif

endmodule

// ===== rtl/tgad_back.sv =====
// Run builder: pixel count, run clamping and the registered result word.
module tgad_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  tgad_pkg::tok_t head_tok,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_kind,
  output logic [31:0]    out_pixel_word,
  output logic [7:0]     out_repeat_count,
  output logic           out_last_run,
  output logic [1:0]     out_error_code,
  output logic [15:0]    out_image_width,
  output logic [15:0]    out_image_height
);
  import tgad_pkg::*;

  logic [31:0] left_r, left_nxt, left_sub;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_load;
  logic        out_kind_r, out_kind_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic [7:0]  out_count_r, out_count_nxt;
  logic        out_last_r, out_last_nxt;
  logic [1:0]  out_err_r, out_err_nxt;
  logic [15:0] out_w_r, out_w_nxt;
  logic [15:0] out_h_r, out_h_nxt;
  logic [7:0]  count;

  // Take a token whenever the output register is free
  assign pop = head_valid && (!out_valid_r || !out_stall);

  always_comb begin
    // Clamp a run to the pixels left in the image
    if (head_tok.is_run) begin
      count = (left_r < {24'd0, head_tok.pkt_left}) ? left_r[7:0] : head_tok.pkt_left;
    end else begin
      count = 8'd1;
    end
    if (count == 8'd0) begin
      count = 8'd1;
    end
    left_sub = left_r - {24'd0, count};

    left_nxt      = left_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_load      = 1'b0;
    out_kind_nxt  = KIND_PIXEL;
    out_word_nxt  = head_tok.word;
    out_count_nxt = count;
    out_last_nxt  = (left_sub == 32'd0);
    out_err_nxt   = ERR_NONE;
    out_w_nxt     = width_r;
    out_h_nxt     = height_r;

    if (pop) begin
      case (head_tok.cmd)
        TOK_START: begin
          left_nxt   = {16'd0, head_tok.width} * {16'd0, head_tok.height};
          width_nxt  = head_tok.width;
          height_nxt = head_tok.height;
        end
        TOK_PIXEL: begin
          // Drop pixels that arrive after the image is complete
          if (left_r != 32'd0) begin
            left_nxt      = left_sub;
            out_valid_nxt = 1'b1;
            out_load      = 1'b1;
          end
        end
        TOK_ERROR: begin
          left_nxt      = 32'd0;
          width_nxt     = head_tok.width;
          height_nxt    = head_tok.height;
          out_valid_nxt = 1'b1;
          out_load      = 1'b1;
          out_kind_nxt  = KIND_ERROR;
          out_word_nxt  = 32'd0;
          out_count_nxt = 8'd0;
          out_last_nxt  = 1'b0;
          out_err_nxt   = head_tok.err;
          out_w_nxt     = head_tok.width;
          out_h_nxt     = head_tok.height;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold image size and the result payload
  always_ff @(posedge clk) begin
    width_r  <= width_nxt;
    height_r <= height_nxt;
    if (out_load) begin
      out_kind_r  <= out_kind_nxt;
      out_word_r  <= out_word_nxt;
      out_count_r <= out_count_nxt;
      out_last_r  <= out_last_nxt;
      out_err_r   <= out_err_nxt;
      out_w_r     <= out_w_nxt;
      out_h_r     <= out_h_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_pixel_word   = out_word_r;
  assign out_repeat_count = out_count_r;
  assign out_last_run     = out_last_r;
  assign out_error_code   = out_err_r;
  assign out_image_width  = out_w_r;
  assign out_image_height = out_h_r;

`ifndef SYNTHESIS
  a_error_emitted: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head_tok.cmd == TOK_ERROR |=> out_valid_r && out_kind_r == KIND_ERROR)
    else $error("header error token produced no error word");
  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_PIXEL |->
      out_repeat_count != 8'd0 && out_repeat_count <= MAX_RUN)
    else $error("pixel word with repeat count out of range");
  a_last_ends_image: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> left_r == 32'd0)
    else $error("last run flagged while pixels remain");
`endif

endmodule

// ===== rtl/tga_image_stream_decoder_top.sv =====
// Top level of the TGA stream decoder: parser, token queue and run builder.
// Takes one file byte per cycle while in_stall is low and gives at most one result word per byte.
// A byte flagged first_byte restarts the parse as header byte zero. The
// 18-byte header and the ID field give no word, except a single error word
// on a bad header, after which bytes are ignored until the next mark. Each
// pixel (raw file or raw packet) or run packet then gives one word with
// its repeat count; runs are clamped to the pixels left and the final word
// carries last_run. Throughput is one byte per cycle while in_stall is low;
// a result passes the token queue, then the output register, after the byte
// that completes it. in_stall rises only when the FIFO_DEPTH-entry token
// queue is full, which happens only while out_stall holds results back.
module tga_image_stream_decoder_top #(
  parameter int unsigned FIFO_DEPTH = tgad_pkg::TGAD_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_file_byte,
  input  logic        in_first_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [31:0] out_pixel_word,
  output logic [7:0]  out_repeat_count,
  output logic        out_last_run,
  output logic [1:0]  out_error_code,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height
);
  import tgad_pkg::*;

  logic byte_take;
  logic tok_push;
  tok_t push_tok;
  logic q_full;
  logic q_pop;
  logic q_valid;
  tok_t head_tok;

  // Take a byte when the queue has room
  assign in_stall  = q_full;
  assign byte_take = in_valid && !q_full;

  tgad_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_take  (byte_take),
    .file_byte  (in_file_byte),
    .first_byte (in_first_byte),
    .tok_push   (tok_push),
    .tok        (push_tok)
  );

  tgad_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (tok_push),
    .push_tok   (push_tok),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_tok   (head_tok)
  );

  tgad_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_valid),
    .head_tok         (head_tok),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_pixel_word   (out_pixel_word),
    .out_repeat_count (out_repeat_count),
    .out_last_run     (out_last_run),
    .out_error_code   (out_error_code),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height)
  );

endmodule

// ===== test/tga_image_stream_decoder_top_test.sv =====
// Self-checking testbench for the TGA stream decoder: files in, run words out.
`timescale 1ns / 1ps

module tga_image_stream_decoder_top_test;
  import tgad_pkg::*;

  localparam int unsigned HEADER_BYTES = 18;
  localparam logic [7:0]  TYPE_RAW     = 8'd2;
  localparam logic [7:0]  TYPE_RLE     = 8'd10;
  localparam logic [7:0]  RUN_FLAG     = 8'd128;
  localparam logic [7:0]  RUN_BIAS     = 8'd127;
  localparam logic [4:0]  DEPTH_GRAY   = 5'd1;
  localparam logic [4:0]  DEPTH_RGB    = 5'd3;
  localparam logic [4:0]  DEPTH_RGBA   = 5'd4;
  localparam int unsigned ITEM_TARGET  = 1300;
  localparam int unsigned DRAIN_LIMIT  = 50000;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_IDSKIP, PH_PKTHDR, PH_PIXEL, PH_DONE
  } parse_phase_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] pixel_word;
    logic [7:0]  repeat_count;
    logic        last_run;
    logic [1:0]  error_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } run_word_t;

  // Tracks the parse of the byte stream and the run words it must produce
  class tga_run_tracker;
    parse_phase_t phase;
    int unsigned  hdr_idx;
    logic [7:0]   id_left;
    logic [15:0]  img_w;
    logic [15:0]  img_h;
    logic [4:0]   depth;
    logic         rle_mode;
    logic         type_good;
    logic [31:0]  pix_left;
    logic [7:0]   pkt_left;
    logic         pkt_run;
    logic [31:0]  assembly;
    logic [1:0]   byte_idx;
    run_word_t    expected_runs[$];
    int unsigned  mismatches;
    int unsigned  files;
    int unsigned  pixel_runs;
    int unsigned  image_ends;
    int unsigned  header_errors;

    function new();
      mismatches = 0;
      files = 0;
      pixel_runs = 0;
      image_ends = 0;
      header_errors = 0;
      restart();
      phase = PH_IDLE;
    endfunction

    function void restart();
      phase = PH_IDLE;
      hdr_idx = 0;
      id_left = '0;
      img_w = '0;
      img_h = '0;
      depth = '0;
      rle_mode = 1'b0;
      type_good = 1'b0;
      pix_left = '0;
      pkt_left = '0;
      pkt_run = 1'b0;
      assembly = '1;
      byte_idx = '0;
    endfunction

    function parse_phase_t data_phase();
      return rle_mode ? PH_PKTHDR : PH_PIXEL;
    endfunction

    function int unsigned pending();
      return expected_runs.size();
    endfunction

    function void expect_run(logic kind, logic [31:0] word, logic [7:0] cnt, logic last,
                             logic [1:0] err);
      run_word_t r;
      r.kind = kind;
      r.pixel_word = word;
      r.repeat_count = cnt;
      r.last_run = last;
      r.error_code = err;
      r.image_width = img_w;
      r.image_height = img_h;
      expected_runs.push_back(r);
    endfunction

    // Advance the parse by one accepted byte
    function void note_byte(logic [7:0] b, logic first);
      logic [1:0]  err;
      logic [31:0] cnt;
      if (first) begin
        restart();
        phase = PH_HEADER;
        files++;
      end
      case (phase)
        PH_HEADER: begin
          case (hdr_idx)
            0: id_left = b;
            2: begin
              rle_mode = (b == TYPE_RLE);
              type_good = (b == TYPE_RAW) || (b == TYPE_RLE);
            end
            12: img_w[7:0] = b;
            13: img_w[15:8] = b;
            14: img_h[7:0] = b;
            15: img_h[15:8] = b;
            16: depth = b[7:3];
            default: ;
          endcase
          if (hdr_idx + 1 < HEADER_BYTES) begin
            hdr_idx++;
          end else begin
            if (img_w == 0 || img_h == 0) err = ERR_ZERO_SIZE;
            else if (depth != DEPTH_GRAY && depth != DEPTH_RGB && depth != DEPTH_RGBA)
              err = ERR_BAD_DEPTH;
            else if (!type_good) err = ERR_BAD_TYPE;
            else err = ERR_NONE;
            if (err != ERR_NONE) begin
              phase = PH_IDLE;
              expect_run(KIND_ERROR, 32'd0, 8'd0, 1'b0, err);
            end else begin
              pix_left = 32'(img_w) * 32'(img_h);
              assembly = '1;
              byte_idx = '0;
              pkt_left = '0;
              pkt_run = 1'b0;
              phase = (id_left != 0) ? PH_IDSKIP : data_phase();
            end
          end
        end
        PH_IDSKIP: begin
          id_left = id_left - 8'd1;
          if (id_left == 0) phase = data_phase();
        end
        PH_PKTHDR: begin
          if (b < RUN_FLAG) begin
            pkt_run = 1'b0;
            pkt_left = b + 8'd1;
          end else begin
            pkt_run = 1'b1;
            pkt_left = b - RUN_BIAS;
          end
          byte_idx = '0;
          phase = PH_PIXEL;
        end
        PH_PIXEL: begin
          assembly[8 * byte_idx +: 8] = b;
          if (depth == DEPTH_GRAY) assembly = {4{b}};
          if (32'(byte_idx) + 1 < 32'(depth)) begin
            byte_idx = byte_idx + 2'd1;
          end else begin
            byte_idx = '0;
            // runs are clamped at the image end
            if (rle_mode && pkt_run) cnt = (32'(pkt_left) < pix_left) ? 32'(pkt_left) : pix_left;
            else cnt = 32'd1;
            if (cnt == 0) cnt = 32'd1;
            pix_left = pix_left - cnt;
            if (rle_mode) begin
              pkt_left = pkt_run ? 8'd0 : pkt_left - 8'd1;
              if (pkt_left == 0) phase = PH_PKTHDR;
            end
            if (pix_left == 0) phase = PH_DONE;
            expect_run(KIND_PIXEL, assembly, cnt[7:0], pix_left == 0, ERR_NONE);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 50) $display("[%0t] %s", $time, msg);
    endtask

    // Compare one accepted result word with the oldest expected one
    task check_run(run_word_t got);
      run_word_t want;
      if (expected_runs.size() == 0) begin
        report($sformatf("unexpected result: kind %0b word %08h count %0d",
                         got.kind, got.pixel_word, got.repeat_count));
        return;
      end
      want = expected_runs.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0b, want %0b", got.kind, want.kind));
      if (got.pixel_word !== want.pixel_word)
        report($sformatf("pixel_word %08h, want %08h", got.pixel_word, want.pixel_word));
      if (got.repeat_count !== want.repeat_count)
        report($sformatf("repeat_count %0d, want %0d", got.repeat_count, want.repeat_count));
      if (got.last_run !== want.last_run)
        report($sformatf("last_run %0b, want %0b", got.last_run, want.last_run));
      if (got.error_code !== want.error_code)
        report($sformatf("error_code %0d, want %0d", got.error_code, want.error_code));
      if (got.image_width !== want.image_width)
        report($sformatf("image_width %04h, want %04h", got.image_width, want.image_width));
      if (got.image_height !== want.image_height)
        report($sformatf("image_height %04h, want %04h", got.image_height, want.image_height));
      if (want.kind == KIND_ERROR) header_errors++;
      else pixel_runs++;
      if (want.last_run) image_ends++;
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_file_byte = 8'd0;
  logic        in_first_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [31:0] out_pixel_word;
  logic [7:0]  out_repeat_count;
  logic        out_last_run;
  logic [1:0]  out_error_code;
  logic [15:0] out_image_width;
  logic [15:0] out_image_height;

  tga_run_tracker sb = new();
  logic           quiet = 1'b0;
  int unsigned    bytes_sent = 0;

  tga_image_stream_decoder_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_file_byte    (in_file_byte),
    .in_first_byte   (in_first_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_pixel_word  (out_pixel_word),
    .out_repeat_count(out_repeat_count),
    .out_last_run    (out_last_run),
    .out_error_code  (out_error_code),
    .out_image_width (out_image_width),
    .out_image_height(out_image_height)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Check accepted results and drive the result-side stall
  initial begin
    run_word_t   got;
    int unsigned hold_left;
    int unsigned open_left;
    hold_left = 0;
    open_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = {out_kind, out_pixel_word, out_repeat_count, out_last_run, out_error_code,
               out_image_width, out_image_height};
        sb.check_run(got);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (open_left != 0) begin
        open_left--;
        out_stall <= 1'b0;
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          open_left = $urandom_range(10, 60);
        end else begin
          hold_left = pick_idle();
          open_left = $urandom_range(0, 3);
        end
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one byte, hold it until accepted, then let the tracker see it
  task automatic send_byte(input logic [7:0] b, input logic first);
    int unsigned gap;
    gap = quiet ? 0 : pick_idle();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_file_byte <= b;
    in_first_byte <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b, first);
    bytes_sent++;
  endtask

  task automatic send_file(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == 0);
  endtask

  // Hold the input until every outstanding word has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic void put_header(ref logic [7:0] q[$], input logic [7:0] id_len,
                                     input logic [7:0] img_type, input logic [15:0] w,
                                     input logic [15:0] h, input logic [7:0] depth_byte);
    q.push_back(id_len);
    q.push_back(8'($urandom));
    q.push_back(img_type);
    repeat (9) q.push_back(8'($urandom));
    q.push_back(w[7:0]);
    q.push_back(w[15:8]);
    q.push_back(h[7:0]);
    q.push_back(h[15:8]);
    q.push_back(depth_byte);
    q.push_back(8'($urandom));
    repeat (id_len) q.push_back(8'($urandom));
  endfunction

  function automatic void put_random(ref logic [7:0] q[$], input int unsigned n);
    repeat (n) q.push_back(8'($urandom));
  endfunction

  // Run-length body; now and then a packet runs past the image end
  function automatic void put_rle_body(ref logic [7:0] q[$], input int unsigned depth,
                                       input int unsigned total, input int unsigned cap_pkts);
    int unsigned left;
    int unsigned n;
    int unsigned pkts;
    left = total;
    pkts = 0;
    while (left > 0 && pkts < cap_pkts) begin
      if ($urandom_range(0, 7) == 0) n = (left + $urandom_range(1, 3) > 128) ? 128 :
                                         left + $urandom_range(1, 3);
      else n = $urandom_range(1, (left < 128) ? left : 128);
      if ($urandom_range(0, 1) == 1) begin
        q.push_back(8'(RUN_BIAS + n));
        put_random(q, depth);
      end else begin
        q.push_back(8'(n - 1));
        put_random(q, n * depth);
      end
      left = (n >= left) ? 0 : left - n;
      pkts++;
    end
  endfunction

  function automatic logic [4:0] pick_depth();
    case ($urandom_range(0, 2))
      0: return DEPTH_GRAY;
      1: return DEPTH_RGB;
      default: return DEPTH_RGBA;
    endcase
  endfunction

  // Complete, well-formed file with random content
  function automatic void build_good_file(ref logic [7:0] q[$]);
    logic [4:0]  depth;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  id_len;
    logic        rle;
    int unsigned r;
    depth = pick_depth();
    rle = 1'($urandom_range(0, 1));
    w = 16'($urandom_range(1, 6));
    h = 16'($urandom_range(1, 6));
    if ($urandom_range(0, 9) == 0) begin
      w = 16'($urandom_range(100, 300));
      h = 16'd1;
      depth = DEPTH_GRAY;
    end
    r = $urandom_range(0, 99);
    if (r < 60) id_len = 8'd0;
    else if (r < 95) id_len = 8'($urandom_range(1, 4));
    else id_len = 8'($urandom);
    put_header(q, id_len, rle ? TYPE_RLE : TYPE_RAW, w, h, {depth, 3'($urandom)});
    if (rle) put_rle_body(q, 32'(depth), 32'(w) * 32'(h), 100000);
    else put_random(q, 32'(w) * 32'(h) * 32'(depth));
  endfunction

  task automatic run_directed();
    logic [7:0] q[$];
    // stray bytes before any mark
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    // every check fails: zero size wins
    q = {};
    put_header(q, 8'd0, 8'd1, 16'd0, 16'd5, 8'h10);
    send_file(q);
    // zero height alone
    q = {};
    put_header(q, 8'd0, TYPE_RAW, 16'd3, 16'd0, 8'h18);
    send_file(q);
    // bad depth at the largest size
    q = {};
    put_header(q, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_file(q);
    // unsupported type, then a byte that is ignored
    q = {};
    put_header(q, 8'd0, 8'd3, 16'd1, 16'd1, 8'h20);
    q.push_back(8'h5A);
    send_file(q);
    // raw gray with an ID field, extreme samples
    q = {};
    put_header(q, 8'd2, TYPE_RAW, 16'd2, 16'd1, 8'h08);
    q.push_back(8'h00);
    q.push_back(8'hFF);
    send_file(q);
    // longest run clamped to a 2x2 image, trailing bytes ignored
    q = {};
    put_header(q, 8'd0, TYPE_RLE, 16'd2, 16'd2, 8'h20);
    q.push_back(8'hFF);
    put_random(q, 6);
    send_file(q);
    // raw packet past the end of a 2x1 RGB image
    q = {};
    put_header(q, 8'd0, TYPE_RLE, 16'd2, 16'd1, 8'h1F);
    q.push_back(8'h02);
    put_random(q, 9);
    send_file(q);
    // abandoned mid-pixel by the next mark
    q = {};
    put_header(q, 8'd0, TYPE_RAW, 16'd4, 16'd4, 8'h18);
    put_random(q, 5);
    send_file(q);
    // huge gray image, abandoned after two packets
    q = {};
    put_header(q, 8'd0, TYPE_RLE, 16'hFFFF, 16'hFFFF, 8'h08);
    q.push_back(RUN_FLAG);
    q.push_back(8'h81);
    q.push_back(8'h00);
    q.push_back(8'h7E);
    send_file(q);
    // mark inside the header
    q = {};
    put_header(q, 8'd0, TYPE_RAW, 16'd1, 16'd1, 8'h18);
    q = q[0:8];
    send_file(q);
    q = {};
    put_header(q, 8'd0, TYPE_RAW, 16'd1, 16'd1, 8'h18);
    put_random(q, 3);
    send_file(q);
  endtask

  task automatic run_random();
    logic [7:0]  q[$];
    int unsigned r;
    int unsigned keep;
    logic [15:0] w;
    logic [15:0] h;
    logic [4:0]  depth;
    while (bytes_sent < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 4) == 0);
      q = {};
      r = $urandom_range(0, 99);
      if (r < 75) begin
        build_good_file(q);
        if ($urandom_range(0, 3) == 0) put_random(q, $urandom_range(1, 3));
      end else if (r < 85) begin
        // bad header, possibly valid by chance
        w = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
        h = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
        put_header(q, 8'($urandom_range(0, 3)), 8'($urandom), w, h, 8'($urandom));
        put_random(q, $urandom_range(0, 4));
      end else if (r < 93) begin
        // truncated file
        build_good_file(q);
        keep = $urandom_range(1, q.size() - 1);
        while (q.size() > keep) void'(q.pop_back());
      end else begin
        // image too big to finish, cut after a few packets or pixels
        depth = pick_depth();
        w = 16'($urandom) | 16'd1;
        h = 16'($urandom) | 16'h8000;
        if ($urandom_range(0, 1) == 1) begin
          put_header(q, 8'd0, TYPE_RLE, w, h, {depth, 3'($urandom)});
          put_rle_body(q, 32'(depth), 32'(w) * 32'(h), $urandom_range(1, 6));
        end else begin
          put_header(q, 8'd0, TYPE_RAW, w, h, {depth, 3'($urandom)});
          put_random(q, 32'(depth) * $urandom_range(1, 10));
        end
      end
      send_file(q);
      if ($urandom_range(0, 11) == 0) drain();
    end
  endtask

  initial begin
    int unsigned waited;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    drain();
    run_random();
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d result words never came", sb.pending()));
    $display("Sent %0d bytes in %0d files; checked %0d pixel runs, %0d image ends,",
             bytes_sent, sb.files, sb.pixel_runs, sb.image_ends);
    $display("and %0d header errors, with random stalls on both sides.", sb.header_errors);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
